// File: src/lswc_pkg.sv
package lswc_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int MAX_CLIPS       = 4;
	localparam int CFG_INDEX_W     = 8;

	localparam logic [3:0] CODE_LEFT   = 4'd1;
	localparam logic [3:0] CODE_RIGHT  = 4'd2;
	localparam logic [3:0] CODE_BOTTOM = 4'd4;
	localparam logic [3:0] CODE_TOP    = 4'd8;

	localparam logic [CFG_INDEX_W-1:0] REG_LEFT   = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RIGHT  = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TOP    = 8'd3;

	typedef struct packed {
		logic load;       // take a new segment
		logic setup;      // pick edge, form operands
		logic mul;        // form product, start divide
		logic div_step;   // one quotient bit
		logic commit;     // move endpoint, stage discarded piece
		logic final_pc;   // stage final piece
	} lswc_cmd_t;

	typedef struct packed {
		logic [3:0] c1;
		logic [3:0] c2;
		logic       div_done;
	} lswc_stat_t;

endpackage

// File: src/lswc_datapath.sv
module lswc_datapath
	import lswc_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_INDEX_W-1:0]        cfg_idx,
	input  logic [COORD_WIDTH-1:0]        cfg_val,
	input  logic [4*COORD_WIDTH-1:0]      seg_in,
	input  lswc_cmd_t                     cmd,
	output lswc_stat_t                    stat,
	output logic [4*COORD_WIDTH-1:0]      piece,
	output logic                          piece_inside,
	output logic                          piece_last
);
	localparam int W    = COORD_WIDTH;
	localparam int PW   = 2 * W + 2;
	localparam int CW   = $clog2(PW + 1);

	logic signed [W-1:0] win_l_q, win_r_q, win_b_q, win_t_q;
	logic signed [W-1:0] x1_q, y1_q, x2_q, y2_q;
	logic signed [W-1:0] base_q, fix_q;
	logic                move_y_q, sel1_q, neg_q, denz_q;
	logic [W:0]          ud_q, un_q, uden_q;
	logic [PW-1:0]       prod_q;
	logic [W:0]          rem_q;
	logic [W-1:0]        quo_q;
	logic [CW-1:0]       cnt_q;
	logic [4*W-1:0]      piece_q;
	logic                inside_q, last_q;

	function automatic logic [3:0] outcode(input logic signed [W-1:0] x,
			input logic signed [W-1:0] y, input logic signed [W-1:0] l,
			input logic signed [W-1:0] r, input logic signed [W-1:0] b,
			input logic signed [W-1:0] t);
		logic [3:0] c;
		c = 4'd0;
		if (x < l)
			c = c | CODE_LEFT;
		else if (x > r)
			c = c | CODE_RIGHT;
		if (y < b)
			c = c | CODE_BOTTOM;
		else if (y > t)
			c = c | CODE_TOP;
		return c;
	endfunction

	function automatic logic [W:0] mag(input logic signed [W:0] v);
		return v[W] ? (~v + 1'b1) : v;
	endfunction

	logic [3:0] c1, c2, co;
	assign c1 = outcode(x1_q, y1_q, win_l_q, win_r_q, win_b_q, win_t_q);
	assign c2 = outcode(x2_q, y2_q, win_l_q, win_r_q, win_b_q, win_t_q);
	assign co = (c1 != 4'd0) ? c1 : c2;

	// operands for the edge being cut
	logic signed [W:0] d_w, n_w, den_w;
	logic signed [W-1:0] base_w, fix_w;
	logic move_y_w;
	always_comb begin
		if ((co & CODE_TOP) != 4'd0) begin
			base_w = x1_q; fix_w = win_t_q; move_y_w = 1'b0;
			d_w   = {x2_q[W-1], x2_q} - {x1_q[W-1], x1_q};
			n_w   = {win_t_q[W-1], win_t_q} - {y1_q[W-1], y1_q};
			den_w = {y2_q[W-1], y2_q} - {y1_q[W-1], y1_q};
		end else if ((co & CODE_BOTTOM) != 4'd0) begin
			base_w = x1_q; fix_w = win_b_q; move_y_w = 1'b0;
			d_w   = {x2_q[W-1], x2_q} - {x1_q[W-1], x1_q};
			n_w   = {win_b_q[W-1], win_b_q} - {y1_q[W-1], y1_q};
			den_w = {y2_q[W-1], y2_q} - {y1_q[W-1], y1_q};
		end else if ((co & CODE_RIGHT) != 4'd0) begin
			base_w = y1_q; fix_w = win_r_q; move_y_w = 1'b1;
			d_w   = {y2_q[W-1], y2_q} - {y1_q[W-1], y1_q};
			n_w   = {win_r_q[W-1], win_r_q} - {x1_q[W-1], x1_q};
			den_w = {x2_q[W-1], x2_q} - {x1_q[W-1], x1_q};
		end else begin
			base_w = y1_q; fix_w = win_l_q; move_y_w = 1'b1;
			d_w   = {y2_q[W-1], y2_q} - {y1_q[W-1], y1_q};
			n_w   = {win_l_q[W-1], win_l_q} - {x1_q[W-1], x1_q};
			den_w = {x2_q[W-1], x2_q} - {x1_q[W-1], x1_q};
		end
	end

	// restoring divide step
	logic [W+1:0] sh_w, diff_w;
	logic         qbit_w;
	assign sh_w   = {rem_q, prod_q[PW-1]};
	assign diff_w = sh_w - {1'b0, uden_q};
	assign qbit_w = !diff_w[W+1];

	// intersection result
	logic [W-1:0] delta_w;
	logic signed [W-1:0] newc_w, nx_w, ny_w;
	assign delta_w = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign newc_w  = denz_q ? base_q : (base_q + $signed(delta_w));
	assign nx_w    = move_y_q ? fix_q : newc_w;
	assign ny_w    = move_y_q ? newc_w : fix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_l_q <= '0;
			win_r_q <= '0;
			win_b_q <= '0;
			win_t_q <= '0;
			cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_LEFT:   win_l_q <= cfg_val;
					REG_RIGHT:  win_r_q <= cfg_val;
					REG_BOTTOM: win_b_q <= cfg_val;
					REG_TOP:    win_t_q <= cfg_val;
					default: ;
				endcase
			end
			if (cmd.mul)
				cnt_q <= CW'(PW);
			else if (cmd.div_step && cnt_q != '0)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x1_q <= seg_in[W-1:0];
			y1_q <= seg_in[2*W-1:W];
			x2_q <= seg_in[3*W-1:2*W];
			y2_q <= seg_in[4*W-1:3*W];
		end
		if (cmd.setup) begin
			base_q   <= base_w;
			fix_q    <= fix_w;
			move_y_q <= move_y_w;
			sel1_q   <= (c1 != 4'd0);
			neg_q    <= (d_w[W] ^ n_w[W]) ^ den_w[W];
			denz_q   <= (den_w == '0);
			ud_q     <= mag(d_w);
			un_q     <= mag(n_w);
			uden_q   <= mag(den_w);
		end
		if (cmd.mul) begin
			prod_q <= ud_q * un_q;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			prod_q <= {prod_q[PW-2:0], 1'b0};
			rem_q  <= qbit_w ? diff_w[W:0] : sh_w[W:0];
			quo_q  <= {quo_q[W-2:0], qbit_w};
		end
		if (cmd.commit) begin
			inside_q <= 1'b0;
			last_q   <= 1'b0;
			if (sel1_q) begin
				piece_q <= {ny_w, nx_w, y1_q, x1_q};
				x1_q    <= nx_w;
				y1_q    <= ny_w;
			end else begin
				piece_q <= {ny_w, nx_w, y2_q, x2_q};
				x2_q    <= nx_w;
				y2_q    <= ny_w;
			end
		end
		if (cmd.final_pc) begin
			piece_q  <= {y2_q, x2_q, y1_q, x1_q};
			inside_q <= (c1 == 4'd0) && (c2 == 4'd0);
			last_q   <= 1'b1;
		end
	end

	assign stat.c1       = c1;
	assign stat.c2       = c2;
	assign stat.div_done = (cnt_q == '0);
	assign piece         = piece_q;
	assign piece_inside  = inside_q;
	assign piece_last    = last_q;

endmodule

// File: src/lswc_ctrl.sv
module lswc_ctrl
	import lswc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic       out_ready,
	input  lswc_stat_t stat,
	output lswc_cmd_t  cmd,
	output logic       idle,
	output logic       out_valid
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_CMT  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;
	localparam logic [2:0] S_LAST = 3'd6;

	logic [2:0] state_q, state_d;
	logic [2:0] clips_q;
	logic       stop_w;

	assign stop_w = (clips_q == 3'(MAX_CLIPS)) ||
		(stat.c1 == 4'd0 && stat.c2 == 4'd0) || ((stat.c1 & stat.c2) != 4'd0);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_fire) begin
				cmd.load = 1'b1;
				state_d  = S_EVAL;
			end
			S_EVAL: begin
				if (stop_w) begin
					cmd.final_pc = 1'b1;
					state_d      = S_LAST;
				end else begin
					cmd.setup = 1'b1;
					state_d   = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					cmd.div_step = 1'b0;
					state_d      = S_CMT;
				end
			end
			S_CMT: begin
				cmd.commit = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT:  if (out_ready) state_d = S_EVAL;
			S_LAST: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			clips_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				clips_q <= '0;
			else if (cmd.commit)
				clips_q <= clips_q + 1'b1;
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT) || (state_q == S_LAST);

endmodule

// File: src/line_segment_window_clipper.sv
// Cohen-Sutherland line clipper against a configurable window.
// Input stream: one beat per segment; s_tdata holds start_x, start_y,
// end_x, end_y. Output stream: one to five beats per segment, each a
// piece (ax, ay, bx, by) with tuser = inside_flag and tlast = last_piece.
// Every cut-away piece comes out as a discarded beat (old endpoint to the
// intersection), and the run closes with the surviving or rejected segment.
// Window registers 0..3 (left, right, bottom, top) are written through the
// cfg channel, which is always ready; write only while the block is idle.
// Each clip step runs the one-bit-per-cycle restoring divider over the
// 2*COORD_WIDTH+2 bit product; a segment takes up to four steps. One
// segment is in flight at a time: s_tready is high only while no segment
// is being worked on.
// Each output beat sits in an output register; while m_tready is low the
// block holds that beat and waits. Reset clears the window to all zeros
// and returns the controller to idle with no beat pending.
module line_segment_window_clipper
	import lswc_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// start_x, start_y, end_x, end_y (low bits first), zero padded
	input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// piece_ax, piece_ay, piece_bx, piece_by (low bits first), zero padded
	output logic [((4*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,
	// inside_flag
	output logic                                  m_tuser,
	output logic                                  m_tlast,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [CFG_INDEX_W-1:0]                cfg_index,
	input  logic [COORD_WIDTH-1:0]                cfg_data
);
	localparam int DW = ((4*COORD_WIDTH+7)/8)*8;

	lswc_cmd_t              cmd;
	lswc_stat_t             stat;
	logic                   idle;
	logic [4*COORD_WIDTH-1:0] piece;

	assign cfg_ready = 1'b1;
	assign s_tready  = idle;

	lswc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (s_tvalid && idle),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd),
		.idle      (idle),
		.out_valid (m_tvalid)
	);

	lswc_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid),
		.cfg_idx      (cfg_index),
		.cfg_val      (cfg_data),
		.seg_in       (s_tdata[4*COORD_WIDTH-1:0]),
		.cmd          (cmd),
		.stat         (stat),
		.piece        (piece),
		.piece_inside (m_tuser),
		.piece_last   (m_tlast)
	);

	assign m_tdata = DW'(piece);

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top
	import lswc_pkg::*;
();

	localparam int CW = 16;
	localparam int DW = 64;
	localparam longint CYCLE_LIMIT = 400000;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
		logic   is_inside;
		logic   last;
	} piece_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [DW-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;

	// window copy kept by the predictor
	coord_t win_left, win_right, win_bottom, win_top;

	piece_t expected_pieces[$];
	int error_count = 0;
	longint cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	line_segment_window_clipper #(.COORD_WIDTH(CW)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("line_segment_window_clipper: mismatch");
			$finish;
		end
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("ERROR %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	function automatic logic [3:0] region_code(input coord_t x, input coord_t y);
		logic [3:0] c;
		c = '0;
		if (x < win_left) c |= CODE_LEFT;
		else if (x > win_right) c |= CODE_RIGHT;
		if (y < win_bottom) c |= CODE_BOTTOM;
		else if (y > win_top) c |= CODE_TOP;
		return c;
	endfunction

	// base + trunc(d*n/den), wrapped to the coordinate width
	function automatic coord_t edge_cross(input longint base, input longint d,
			input longint n, input longint den);
		longint q;
		if (den == 0) return coord_t'(base);
		q = (d * n) / den;
		return coord_t'(base + q);
	endfunction

	// predict every piece that one segment produces
	task automatic predict_clip(input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey);
		coord_t x1, y1, x2, y2, nx, ny;
		logic [3:0] c1, c2, co;
		int k;
		x1 = sx; y1 = sy; x2 = ex; y2 = ey;
		c1 = region_code(x1, y1);
		c2 = region_code(x2, y2);
		for (k = 0; k < MAX_CLIPS; k++) begin
			if (c1 == 0 && c2 == 0) begin
				expected_pieces.push_back('{x1, y1, x2, y2, 1'b1, 1'b1});
				return;
			end
			if ((c1 & c2) != 0) begin
				expected_pieces.push_back('{x1, y1, x2, y2, 1'b0, 1'b1});
				return;
			end
			co = (c1 != 0) ? c1 : c2;
			if (co & CODE_TOP) begin
				nx = edge_cross(x1, longint'(x2) - x1, longint'(win_top) - y1,
					longint'(y2) - y1);
				ny = win_top;
			end else if (co & CODE_BOTTOM) begin
				nx = edge_cross(x1, longint'(x2) - x1, longint'(win_bottom) - y1,
					longint'(y2) - y1);
				ny = win_bottom;
			end else if (co & CODE_RIGHT) begin
				ny = edge_cross(y1, longint'(y2) - y1, longint'(win_right) - x1,
					longint'(x2) - x1);
				nx = win_right;
			end else begin
				ny = edge_cross(y1, longint'(y2) - y1, longint'(win_left) - x1,
					longint'(x2) - x1);
				nx = win_left;
			end
			if (c1 != 0) begin
				expected_pieces.push_back('{x1, y1, nx, ny, 1'b0, 1'b0});
				x1 = nx; y1 = ny; c1 = region_code(x1, y1);
			end else begin
				expected_pieces.push_back('{x2, y2, nx, ny, 1'b0, 1'b0});
				x2 = nx; y2 = ny; c2 = region_code(x2, y2);
			end
		end
		expected_pieces.push_back('{x1, y1, x2, y2,
			(c1 == 0 && c2 == 0), 1'b1});
	endtask

	// receiver: random stall, compare each accepted beat
	always @(posedge clk) begin
		piece_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_pieces.size() == 0) begin
					report("unexpected beat", m_tdata[CW-1:0], 0);
				end else begin
					want = expected_pieces.pop_front();
					if (coord_t'(m_tdata[0*CW +: CW]) != want.ax)
						report("piece_ax", coord_t'(m_tdata[0*CW +: CW]), want.ax);
					if (coord_t'(m_tdata[1*CW +: CW]) != want.ay)
						report("piece_ay", coord_t'(m_tdata[1*CW +: CW]), want.ay);
					if (coord_t'(m_tdata[2*CW +: CW]) != want.bx)
						report("piece_bx", coord_t'(m_tdata[2*CW +: CW]), want.bx);
					if (coord_t'(m_tdata[3*CW +: CW]) != want.by)
						report("piece_by", coord_t'(m_tdata[3*CW +: CW]), want.by);
					if (m_tuser != want.is_inside)
						report("inside_flag", m_tuser, want.is_inside);
					if (m_tlast != want.last)
						report("last_piece", m_tlast, want.last);
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_segment(input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {ey, ex, sy, sx};
		do @(posedge clk); while (!s_tready);
		predict_clip(sx, sy, ex, ey);
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// hold until every expected piece is out, then let the block settle
	task automatic drain;
		while (expected_pieces.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input coord_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LEFT: win_left = val;
			REG_RIGHT: win_right = val;
			REG_BOTTOM: win_bottom = val;
			REG_TOP: win_top = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_window(input coord_t l, input coord_t r,
			input coord_t b, input coord_t t);
		drain();
		write_reg(REG_LEFT, l);
		write_reg(REG_RIGHT, r);
		write_reg(REG_BOTTOM, b);
		write_reg(REG_TOP, t);
	endtask

	function automatic coord_t near_coord(input coord_t lo, input coord_t hi);
		return coord_t'((longint'(lo) + hi) / 2 + $signed($urandom_range(600)) - 300);
	endfunction

	// reset window: degenerate single point at origin
	task automatic test_reset_window;
		send_segment(0, 0, 0, 0);
		send_segment(-1, 1, 1, -1);
		send_segment(5, 5, 7, 9);
	endtask

	task automatic test_directed;
		set_window(-100, 100, -50, 50);
		send_segment(0, 0, 10, 10);                // trivial accept
		send_segment(200, 200, 300, 300);          // trivial reject
		send_segment(-200, 0, 200, 0);             // left and right cut
		send_segment(0, -200, 0, 200);             // bottom and top cut
		send_segment(-300, -120, 300, 130);        // four clip steps
		send_segment(-32768, -32768, 32767, 32767);
		send_segment(32767, -32768, -32768, 32767);
		send_segment(0, 0, 32767, 0);              // second endpoint clipped
		send_segment(-150, 90, 150, -60);
		// unknown register index is ignored
		drain();
		write_reg(8'd7, 16'sd1234);
		write_reg(8'hff, -16'sd1);
		send_segment(100, 50, -100, -50);
		// window at the extremes
		set_window(-32768, 32767, -32768, 32767);
		send_segment(-32768, 32767, 32767, -32768);
		// inverted window
		set_window(100, -100, 50, -50);
		send_segment(0, 0, 10, 10);
		send_segment(-200, -90, 200, 90);
		send_segment(-32768, 32767, 32767, -32768);
		// very narrow window with wraparound-prone intersections
		set_window(32767, 32767, -32768, -32768);
		send_segment(-32768, 32767, 32767, -32768);
		send_segment(0, 0, 32767, -32768);
	endtask

	task automatic random_phase(input int n, input int idle, input int stall);
		coord_t l, r, b, t;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		l = coord_t'($urandom); r = coord_t'($urandom);
		b = coord_t'($urandom); t = coord_t'($urandom);
		if (l > r) begin coord_t z; z = l; l = r; r = z; end
		if (b > t) begin coord_t z; z = b; b = t; t = z; end
		if ($urandom_range(1)) begin
			l = coord_t'($signed($urandom_range(200)) - 300);
			r = coord_t'(l + $urandom_range(400));
			b = coord_t'($signed($urandom_range(200)) - 300);
			t = coord_t'(b + $urandom_range(400));
		end
		set_window(l, r, b, t);
		repeat (n) begin
			if ($urandom_range(3) == 0)
				send_segment(coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), coord_t'($urandom));
			else
				send_segment(coord_t'(near_coord(l, r) * 2),
					coord_t'(near_coord(b, t) * 2),
					coord_t'(near_coord(l, r) * 2),
					coord_t'(near_coord(b, t) * 2));
		end
	endtask

	initial begin
		win_left = 0; win_right = 0; win_bottom = 0; win_top = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_window();
		test_directed();
		random_phase(34, 8, 82);
		random_phase(34, 82, 8);
		random_phase(34, 0, 0);
		drain();
		if (error_count == 0)
			$display("line_segment_window_clipper: match");
		else
			$display("line_segment_window_clipper: mismatch");
		$finish;
	end

endmodule
